// ===== hdl/emc_pkg.sv =====
// Shared types and constants for the evidential mass combiner.
// No dependencies.
`default_nettype none
package emc_pkg;
    localparam int EMC_FRAC_BITS = 15;
    localparam int MASS_W = 16;
    localparam int PROD_W = 2 * MASS_W;      // one 16x16 product
    localparam int TOT_W  = PROD_W + 4;      // sum of all nine products
    localparam int NLANE  = 4;

    typedef logic [MASS_W-1:0] t_mass;
    typedef logic [TOT_W-1:0]  t_tot;

    // results that skip the divider, kept in step with it
    typedef struct packed {
        logic              norm;
        logic              zero;
        t_mass [NLANE-1:0] raw;
    } t_side;
endpackage
`default_nettype wire

// ===== hdl/emc_mul_sum.sv =====
// Three-stage product and sum front end: products, class sums, total.
// Uses emc_pkg.
`default_nettype none
module emc_mul_sum import emc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire t_mass             i_fa,
    input  wire t_mass             i_oa,
    input  wire t_mass             i_ua,
    input  wire t_mass             i_fb,
    input  wire t_mass             i_ob,
    input  wire t_mass             i_ub,
    output t_tot [NLANE-1:0]       o_p,
    output t_tot                   o_sum
);
    logic [PROD_W-1:0] r_m [0:8];
    t_tot [NLANE-1:0]  r_p2;
    t_tot [NLANE-1:0]  r_p3;
    t_tot              r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= i_fa * i_fb;
            r_m[1] <= i_fa * i_ub;
            r_m[2] <= i_ua * i_fb;
            r_m[3] <= i_oa * i_ob;
            r_m[4] <= i_oa * i_ub;
            r_m[5] <= i_ua * i_ob;
            r_m[6] <= i_fa * i_ob;
            r_m[7] <= i_oa * i_fb;
            r_m[8] <= i_ua * i_ub;
            r_p2[0] <= TOT_W'(r_m[0]) + TOT_W'(r_m[1]) + TOT_W'(r_m[2]);
            r_p2[1] <= TOT_W'(r_m[3]) + TOT_W'(r_m[4]) + TOT_W'(r_m[5]);
            r_p2[2] <= TOT_W'(r_m[6]) + TOT_W'(r_m[7]);
            r_p2[3] <= TOT_W'(r_m[8]);
            r_p3  <= r_p2;
            r_sum <= r_p2[0] + r_p2[1] + r_p2[2] + r_p2[3];
        end
    end

    assign o_p   = r_p3;
    assign o_sum = r_sum;
endmodule
`default_nettype wire

// ===== hdl/emc_div_lane.sv =====
// Pipelined restoring fraction divider, one quotient bit per stage.
// Gives floor(num * 2^FRAC_BITS / den), limited to 1.0. Uses emc_pkg.
`default_nettype none
module emc_div_lane import emc_pkg::*; #(
    parameter int FRAC_BITS = EMC_FRAC_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire t_tot              i_num,
    input  wire t_tot              i_den,
    output logic [FRAC_BITS:0]     o_quo
);
    t_tot                 r_rem [0:FRAC_BITS];
    t_tot                 r_den [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_quo [0:FRAC_BITS];
    logic                 r_sat [0:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_sat[0] <= (i_num >= i_den);
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
        logic [TOT_W:0] w_sh;
        logic [TOT_W:0] w_den;
        logic           w_ge;
        assign w_sh  = {r_rem[k-1], 1'b0};
        assign w_den = {1'b0, r_den[k-1]};
        assign w_ge  = (w_sh >= w_den);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? TOT_W'(w_sh - w_den) : TOT_W'(w_sh);
                r_den[k] <= r_den[k-1];
                r_quo[k] <= {r_quo[k-1][FRAC_BITS-2:0], w_ge};
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_quo = r_sat[FRAC_BITS] ? {1'b1, {FRAC_BITS{1'b0}}}
                                    : {1'b0, r_quo[FRAC_BITS]};
endmodule
`default_nettype wire

// ===== hdl/evidential_mass_combine.sv =====
// Conjunctive combination of two free/occupied/unknown mass triples.
// Path from input request to output register: the 3-stage front end,
// the one-bit-per-stage divider and the output register.
// Throughput: one request per cycle; the whole pipeline freezes while a held
// output is stalled.
// Reset: synchronous active-low; clears valid bits, normalize enable resets to 1.
`default_nettype none
module evidential_mass_combine import emc_pkg::*; #(
    parameter int MASS_FRAC_BITS = EMC_FRAC_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire logic  i_cfg_normalize_enable,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_mass i_a_free,
    input  wire t_mass i_a_occupied,
    input  wire t_mass i_a_unknown,
    input  wire t_mass i_b_free,
    input  wire t_mass i_b_occupied,
    input  wire t_mass i_b_unknown,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_mass      o_out_free,
    output t_mass      o_out_occupied,
    output t_mass      o_out_conflict,
    output t_mass      o_out_unknown,
    output logic       o_zero_sum
);
    localparam int F     = MASS_FRAC_BITS;
    localparam int DEPTH = F + 4;   // front end 3 + divider F+1
    localparam logic [TOT_W-1:0] LIM =
        (F >= MASS_W) ? TOT_W'(17'h0FFFF) : (TOT_W'(1) << F);

    logic              r_norm;
    logic              w_en;
    logic [DEPTH-1:0]  r_vld;
    t_tot [NLANE-1:0]  w_p;
    t_tot              w_sum;
    t_side             w_side;
    t_side             r_side [0:F];
    logic [F:0]        w_quo [NLANE];
    logic              r_norm_s [0:2];
    logic              r_out_valid;
    t_mass [NLANE-1:0] r_out;
    logic              r_zero;

    assign w_en        = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm <= 1'b1;
        end else if (i_cfg_valid) begin
            r_norm <= i_cfg_normalize_enable;
        end
    end

    emc_mul_sum u_front (
        .i_clk (i_clk), .i_en (w_en),
        .i_fa (i_a_free), .i_oa (i_a_occupied), .i_ua (i_a_unknown),
        .i_fb (i_b_free), .i_ob (i_b_occupied), .i_ub (i_b_unknown),
        .o_p (w_p), .o_sum (w_sum)
    );

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        emc_div_lane #(.FRAC_BITS(F)) u_div (
            .i_clk (i_clk), .i_en (w_en),
            .i_num (w_p[l]), .i_den (w_sum), .o_quo (w_quo[l])
        );
        logic [TOT_W-1:0] w_shr;
        assign w_shr = w_p[l] >> F;
        assign w_side.raw[l] = MASS_W'((w_shr > LIM) ? LIM : w_shr);
    end
    assign w_side.norm = r_norm_s[2];
    assign w_side.zero = (w_sum == '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_norm_s[0] <= r_norm;
            r_norm_s[1] <= r_norm_s[0];
            r_norm_s[2] <= r_norm_s[1];
            r_side[0]   <= w_side;
            for (int k = 1; k <= F; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[DEPTH-2:0], i_in_valid};
            r_out_valid <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero <= r_side[F].norm && r_side[F].zero;
            for (int l = 0; l < NLANE; l++) begin
                if (!r_side[F].norm) begin
                    r_out[l] <= r_side[F].raw[l];
                end else if (r_side[F].zero) begin
                    r_out[l] <= '0;
                end else if (TOT_W'(w_quo[l]) > LIM) begin
                    r_out[l] <= MASS_W'(LIM);
                end else begin
                    r_out[l] <= MASS_W'(w_quo[l]);
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_free     = r_out[0];
    assign o_out_occupied = r_out[1];
    assign o_out_conflict = r_out[2];
    assign o_out_unknown  = r_out[3];
    assign o_zero_sum     = r_zero;

    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_sum |-> (o_out_free == '0) && (o_out_occupied == '0)
            && (o_out_conflict == '0) && (o_out_unknown == '0))
        else $error("zero_sum with nonzero mass");
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (TOT_W'(o_out_free) <= LIM) && (TOT_W'(o_out_unknown) <= LIM))
        else $error("mass above 1.0");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

// ===== sim/evidential_mass_combine_tb.sv =====
// Testbench for evidential_mass_combine: random and directed mass pairs,
// predicted conjunctive combination checked field by field at the output.
// Depends on emc_pkg and the evidential_mass_combine RTL.
`timescale 1ns / 1ps
`default_nettype none
module evidential_mass_combine_tb import emc_pkg::*; ();

    localparam int FB = EMC_FRAC_BITS;
    localparam int LATENCY = FB + 5;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] ONE = 64'd1 << FB;

    typedef struct packed {
        t_mass fr;
        t_mass oc;
        t_mass cf;
        t_mass un;
        logic  zs;
    } t_comb;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_cfg_valid = 1'b0;
    logic  i_cfg_normalize_enable = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  i_out_stall = 1'b0;
    t_mass i_a_free = '0, i_a_occupied = '0, i_a_unknown = '0;
    t_mass i_b_free = '0, i_b_occupied = '0, i_b_unknown = '0;
    logic  o_cfg_ready, o_in_stall, o_out_valid, o_zero_sum;
    t_mass o_out_free, o_out_occupied, o_out_conflict, o_out_unknown;

    evidential_mass_combine u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_normalize_enable(i_cfg_normalize_enable),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_a_free(i_a_free), .i_a_occupied(i_a_occupied), .i_a_unknown(i_a_unknown),
        .i_b_free(i_b_free), .i_b_occupied(i_b_occupied), .i_b_unknown(i_b_unknown),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_free(o_out_free), .o_out_occupied(o_out_occupied),
        .o_out_conflict(o_out_conflict), .o_out_unknown(o_out_unknown),
        .o_zero_sum(o_zero_sum)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    logic   norm_en = 1'b1;
    t_comb  expected_q[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;

    function automatic logic [63:0] frac_quot(logic [63:0] x, logic [63:0] d);
        logic [63:0] r, q;
        r = x;
        q = 0;
        if (x >= d) return ONE;
        for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_mass sat_mass(logic [63:0] v);
        logic [63:0] lim;
        lim = (ONE > 64'hFFFF) ? 64'hFFFF : ONE;
        return (v > lim) ? lim[15:0] : v[15:0];
    endfunction

    function automatic t_comb combine_masses(t_mass fa, t_mass oa, t_mass ua,
                                             t_mass fb, t_mass ob, t_mass ub);
        logic [63:0] p[4];
        logic [63:0] total;
        t_mass m[4];
        t_comb c;
        p[0] = 64'(fa) * fb + 64'(fa) * ub + 64'(ua) * fb;
        p[1] = 64'(oa) * ob + 64'(oa) * ub + 64'(ua) * ob;
        p[2] = 64'(fa) * ob + 64'(oa) * fb;
        p[3] = 64'(ua) * ub;
        total = p[0] + p[1] + p[2] + p[3];
        for (int k = 0; k < 4; k++) begin
            if (norm_en) m[k] = (total == 0) ? '0 : sat_mass(frac_quot(p[k], total));
            else m[k] = sat_mass(p[k] >> FB);
        end
        c.fr = m[0];
        c.oc = m[1];
        c.cf = m[2];
        c.un = m[3];
        c.zs = norm_en && (total == 0);
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // valid stays high into the next request when there is no gap
    task automatic send_request(t_mass fa, t_mass oa, t_mass ua,
                                t_mass fb, t_mass ob, t_mass ub);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_a_free <= fa; i_a_occupied <= oa; i_a_unknown <= ua;
        i_b_free <= fb; i_b_occupied <= ob; i_b_unknown <= ub;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_q.push_back(combine_masses(fa, oa, ua, fb, ob, ub));
        @(negedge i_clk);
    endtask

    // receiver stall and result check
    always @(negedge i_clk) i_out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        t_comb e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 16'd0, 16'd0);
            end else begin
                e = expected_q.pop_front();
                if (o_out_free !== e.fr) report_mismatch("free", o_out_free, e.fr);
                if (o_out_occupied !== e.oc)
                    report_mismatch("occupied", o_out_occupied, e.oc);
                if (o_out_conflict !== e.cf)
                    report_mismatch("conflict", o_out_conflict, e.cf);
                if (o_out_unknown !== e.un) report_mismatch("unknown", o_out_unknown, e.un);
                if (o_zero_sum !== e.zs)
                    report_mismatch("zero_sum", {15'd0, o_zero_sum}, {15'd0, e.zs});
            end
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic write_normalize(logic en);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_normalize_enable <= en;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        norm_en = en;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_mass rand_mass();
        case ($urandom_range(9))
            0: return '0;
            1: return ONE[15:0];
            2: return 16'hFFFF;
            3: return 16'($urandom);
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    task automatic test_directed;
        t_mass ex[6];
        ex = '{16'd0, 16'd1, 16'd16384, 16'd32767, 16'd32768, 16'hFFFF};
        send_request(0, 0, 0, 0, 0, 0);                   // zero sum
        send_request(16'h8000, 0, 0, 16'h8000, 0, 0);     // certain free
        send_request(16'h8000, 0, 0, 0, 16'h8000, 0);     // total conflict
        send_request(0, 0, 16'h8000, 0, 0, 16'h8000);     // full ignorance
        send_request(0, 16'h8000, 0, 0, 0, 16'h8000);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(0, 0, 16'h0001, 0, 0, 16'h0001);     // tiny sum
        send_request(16'h4000, 16'h2000, 16'h2000, 16'h2000, 16'h4000, 16'h2000);
        for (int i = 0; i < 6; i++)
            send_request(ex[i], ex[5 - i], ex[(i + 2) % 6], ex[(i + 3) % 6],
                         ex[(i + 1) % 6], ex[(i + 4) % 6]);
    endtask

    task automatic test_random(int n);
        int fa, oa, fb, ob;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) != 0) begin
                // well-formed masses summing to 1.0
                fa = $urandom_range(32768); oa = $urandom_range(32768 - fa);
                fb = $urandom_range(32768); ob = $urandom_range(32768 - fb);
                send_request(16'(fa), 16'(oa), 16'(32768 - fa - oa),
                             16'(fb), 16'(ob), 16'(32768 - fb - ob));
            end else begin
                send_request(rand_mass(), rand_mass(), rand_mass(),
                             rand_mass(), rand_mass(), rand_mass());
            end
        end
    endtask

    task automatic test_phase(int sp, int rp, int n);
        send_idle_pct = sp;
        stall_pct = rp;
        test_random(n);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_phase(0, 0, 100);
        write_normalize(1'b0);
        test_directed();
        test_phase(58, 0, 120);
        write_normalize(1'b1);
        test_phase(0, 58, 120);
        write_normalize(1'b0);
        test_phase(13, 13, 120);
        write_normalize(1'b1);
        test_directed();
        test_phase(58, 58, 120);
        test_phase(0, 0, 128);
        drain();
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
